### sv/assert_macros.svh
// Assertion macros shared by the timer table RTL; empty when SYNTH is set.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Property must hold at every clock edge out of reset.
`define MSTT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// Condition must never be true out of reset.
`define MSTT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define MSTT_ASSERT(lbl, prop, msg)
`define MSTT_NEVER(lbl, cond, msg)
`endif
`endif

### sv/mstt_pkg.sv
// Shared types and constants of the timer slot table.
package mstt_pkg;

  // Input beat kinds
  typedef enum logic [1:0] {
    KIND_START    = 2'd0,
    KIND_STOP     = 2'd1,
    KIND_TICK     = 2'd2,
    KIND_DISPATCH = 2'd3
  } kind_e;

  // Result beat kinds
  typedef enum logic [1:0] {
    REPLY_START = 2'd0,
    REPLY_STOP  = 2'd1,
    REPLY_FIRE  = 2'd2,
    REPLY_DONE  = 2'd3
  } reply_e;

  // Result status codes
  typedef enum logic {
    STATUS_OK     = 1'b0,
    STATUS_REJECT = 1'b1
  } status_e;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CLAIM = 2'd1,
    ST_FIRE  = 2'd2
  } state_e;

  localparam int SlotW    = 3;
  localparam int MaxFires = 8;
  localparam int FireCntW = 4;

  // Broadcast from the controller to every cell of the chain
  typedef struct packed {
    logic             claim;      // token looks for a free slot
    logic             commit;     // token holder applies its update
    logic             advance;    // shift token one cell along
    logic             clear;      // drop the token
    logic             tick;       // count down active slots not yet at zero
    logic             stop;       // free the slot named by stop_slot
    logic [SlotW-1:0] stop_slot;
  } cell_cmd_t;

endpackage

### sv/mstt_cell.sv
// One timer slot of the chain: slot state plus one stage of the scan token.
module mstt_cell #(
  parameter int COUNT_WIDTH = 16,
  parameter int INDEX       = 0
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  mstt_pkg::cell_cmd_t   cmd_i,
  input  logic [COUNT_WIDTH-1:0] period_i,
  input  logic                  no_reload_i,
  input  logic                  tok_i,
  output logic                  tok_o,
  output logic                  hit_o
);
  import mstt_pkg::*;

  logic                   active_q, active_d;
  logic                   tok_q, tok_d;
  logic [COUNT_WIDTH-1:0] period_q, period_d;
  logic [COUNT_WIDTH-1:0] rem_q, rem_d;
  logic                   no_reload_q, no_reload_d;
  logic                   expired;
  logic                   stop_hit;
  logic                   take;

  assign expired  = active_q && (rem_q == '0);
  assign stop_hit = cmd_i.stop && (int'(cmd_i.stop_slot) == INDEX);
  assign take     = cmd_i.commit && tok_q;

  // Report a match only while holding the token
  assign hit_o = tok_q && (cmd_i.claim ? !active_q : expired);
  assign tok_o = tok_q;

  // Shift the token, or drop it
  always_comb begin
    tok_d = tok_q;
    if (cmd_i.clear) begin
      tok_d = 1'b0;
    end else if (cmd_i.advance) begin
      tok_d = tok_i;
    end
  end

  // Update slot state
  always_comb begin
    active_d    = active_q;
    period_d    = period_q;
    rem_d       = rem_q;
    no_reload_d = no_reload_q;
    if (take && cmd_i.claim) begin
      active_d    = 1'b1;
      period_d    = period_i;
      rem_d       = period_i;
      no_reload_d = no_reload_i;
    end else if (take) begin
      if (no_reload_q) begin
        active_d = 1'b0;
      end else begin
        rem_d = period_q;
      end
    end else if (stop_hit) begin
      active_d = 1'b0;
    end else if (cmd_i.tick && active_q && (rem_q != '0)) begin
      rem_d = rem_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      tok_q    <= 1'b0;
    end else begin
      active_q <= active_d;
      tok_q    <= tok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    period_q    <= period_d;
    rem_q       <= rem_d;
    no_reload_q <= no_reload_d;
  end

endmodule

### sv/mstt_ctrl.sv
// Sequencer of the timer table: input decode, token walk and result register.
`include "assert_macros.svh"
module mstt_ctrl #(
  parameter int TIMER_COUNT = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [1:0]             kind_i,
  input  logic [2:0]             timer_slot_i,
  input  logic [15:0]            period_i,
  input  logic                   no_reload_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [1:0]             reply_kind_o,
  output logic                   status_o,
  output logic [2:0]             slot_o,
  output logic                   last_o,
  output mstt_pkg::cell_cmd_t    cmd_o,
  output logic [COUNT_WIDTH-1:0] period_o,
  output logic                   no_reload_o,
  output logic                   inject_o,
  input  logic                   tok_last_i,
  input  logic                   hit_i
);
  import mstt_pkg::*;

  localparam int IdxW = $clog2(TIMER_COUNT + 1);

  state_e                 state_q, state_d;
  logic                   end_q, end_d;
  logic [IdxW-1:0]        idx_q, idx_d;
  logic [FireCntW-1:0]    fires_q, fires_d;
  logic [COUNT_WIDTH-1:0] period_q;
  logic                   no_reload_q;
  logic                   out_valid_q;
  logic [1:0]             reply_kind_q;
  logic                   status_q;
  logic [2:0]             slot_q;
  logic                   last_q;

  logic                   can_load, accept, load;
  logic [COUNT_WIDTH-1:0] period_c;
  logic                   period_zero, stop_rej, fire_room;
  kind_e                  kind;
  logic                   emit;
  reply_e                 e_kind;
  status_e                e_status;
  logic [2:0]             e_slot;
  logic                   e_last;
  logic                   inject, walk_adv, commit, clear, tick, stop, fires_inc;

  assign can_load    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = (state_q != ST_IDLE) || !can_load;
  assign accept      = in_valid_i && !in_stall_o;
  assign kind        = kind_e'(kind_i);
  assign period_c    = COUNT_WIDTH'(period_i);
  assign period_zero = (period_c == '0);
  assign stop_rej    = int'(timer_slot_i) >= TIMER_COUNT;
  assign fire_room   = fires_q < FireCntW'(MaxFires);
  assign load        = emit && can_load;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && kind == KIND_START && !period_zero) begin
          state_d = ST_CLAIM;
        end else if (accept && kind == KIND_DISPATCH) begin
          state_d = ST_FIRE;
        end
      end
      ST_CLAIM: begin
        if ((end_q || hit_i) && can_load) begin
          state_d = ST_IDLE;
        end
      end
      ST_FIRE: begin
        if (end_q && can_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    emit      = 1'b0;
    e_kind    = REPLY_START;
    e_status  = STATUS_OK;
    e_slot    = '0;
    e_last    = 1'b1;
    inject    = 1'b0;
    walk_adv  = 1'b0;
    commit    = 1'b0;
    clear     = 1'b0;
    tick      = 1'b0;
    stop      = 1'b0;
    fires_inc = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (kind)
            KIND_START: begin
              if (period_zero) begin
                emit     = 1'b1;
                e_status = STATUS_REJECT;
              end else begin
                inject = 1'b1;
              end
            end
            KIND_STOP: begin
              emit     = 1'b1;
              e_kind   = REPLY_STOP;
              e_status = stop_rej ? STATUS_REJECT : STATUS_OK;
              e_slot   = timer_slot_i;
              stop     = !stop_rej;
            end
            KIND_TICK: tick = 1'b1;
            KIND_DISPATCH: inject = 1'b1;
            default: ;
          endcase
        end
      end
      ST_CLAIM: begin
        if (end_q) begin
          emit     = 1'b1;
          e_status = STATUS_REJECT;
          clear    = can_load;
        end else if (hit_i) begin
          emit   = 1'b1;
          e_slot = 3'(idx_q);
          commit = can_load;
          clear  = can_load;
        end else begin
          walk_adv = 1'b1;
        end
      end
      ST_FIRE: begin
        if (end_q) begin
          emit   = 1'b1;
          e_kind = REPLY_DONE;
          clear  = can_load;
        end else if (hit_i && fire_room) begin
          emit      = 1'b1;
          e_kind    = REPLY_FIRE;
          e_slot    = 3'(idx_q);
          e_last    = 1'b0;
          commit    = can_load;
          walk_adv  = can_load;
          fires_inc = can_load;
        end else begin
          walk_adv = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Cell broadcast
  always_comb begin
    cmd_o           = '0;
    cmd_o.claim     = (state_q == ST_CLAIM);
    cmd_o.commit    = commit;
    cmd_o.advance   = inject || walk_adv;
    cmd_o.clear     = clear;
    cmd_o.tick      = tick;
    cmd_o.stop      = stop;
    cmd_o.stop_slot = timer_slot_i;
  end
  assign inject_o    = inject;
  assign period_o    = period_q;
  assign no_reload_o = no_reload_q;

  // Track token position, end of chain and fire count
  always_comb begin
    end_d   = end_q;
    idx_d   = idx_q;
    fires_d = fires_q;
    if (clear) begin
      end_d = 1'b0;
    end else if (inject || walk_adv) begin
      end_d = tok_last_i;
    end
    if (inject) begin
      idx_d   = '0;
      fires_d = '0;
    end else begin
      if (walk_adv) begin
        idx_d = idx_q + 1'b1;
      end
      if (fires_inc) begin
        fires_d = fires_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      end_q       <= 1'b0;
      idx_q       <= '0;
      fires_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      end_q   <= end_d;
      idx_q   <= idx_d;
      fires_q <= fires_d;
      if (can_load) begin
        out_valid_q <= emit;
      end
    end
  end

  // Hold start request and result beat
  always_ff @(posedge clk_i) begin
    if (accept && kind == KIND_START) begin
      period_q    <= period_c;
      no_reload_q <= no_reload_i;
    end
    if (load) begin
      reply_kind_q <= e_kind;
      status_q     <= e_status;
      slot_q       <= e_slot;
      last_q       <= e_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign reply_kind_o = reply_kind_q;
  assign status_o     = status_q;
  assign slot_o       = slot_q;
  assign last_o       = last_q;

  `MSTT_ASSERT(a_commit_load, commit |-> load, "slot update without result beat")
  `MSTT_ASSERT(a_done_idle, (state_q == ST_FIRE && end_q && load) |=> (state_q == ST_IDLE), "dispatch did not close")
  `MSTT_NEVER(a_fire_cap, fires_q > FireCntW'(MaxFires), "fire count above limit")
  `MSTT_NEVER(a_idle_token, state_q == ST_IDLE && end_q, "token left over in idle")

endmodule

### sv/multi_slot_timer_table.sv
// Top level of the timer slot table: sequencer and chain of slot cells.
//
// Input channel (in_valid_i / in_stall_o) takes one beat per command:
// start, stop, tick or dispatch. Output channel (out_valid_o / out_stall_i)
// returns result beats; last_o marks the final beat of a command.
// Tick and stop leave the sequencer idle; a stop reply is ready the next cycle.
// Start and dispatch walk a token through the chain of TIMER_COUNT cells,
// one cell per cycle unless a hit or the chain end waits on a stalled
// output. The next command is taken once the block is idle again.
// Fires leave at most one per cycle, in ascending slot order, then done.
// A stalled receiver holds the walk at a hit or at the chain end and
// holds the output beat; a new command waits until the output register
// can take its result.
// Reset clears all active flags and the sequencer; slot counts and periods
// are written by a start before they are read.
`include "assert_macros.svh"
module multi_slot_timer_table #(
  parameter int TIMER_COUNT = 8,
  parameter int COUNT_WIDTH = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  kind_i,
  input  logic [2:0]  timer_slot_i,
  input  logic [15:0] period_i,
  input  logic        no_reload_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  reply_kind_o,
  output logic        status_o,
  output logic [2:0]  slot_o,
  output logic        last_o
);
  import mstt_pkg::*;

  cell_cmd_t              cmd;
  logic [COUNT_WIDTH-1:0] period;
  logic                   no_reload;
  logic [TIMER_COUNT:0]   tok_chain;
  logic [TIMER_COUNT-1:0] hits;

  mstt_ctrl #(
    .TIMER_COUNT(TIMER_COUNT),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .timer_slot_i (timer_slot_i),
    .period_i     (period_i),
    .no_reload_i  (no_reload_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reply_kind_o (reply_kind_o),
    .status_o     (status_o),
    .slot_o       (slot_o),
    .last_o       (last_o),
    .cmd_o        (cmd),
    .period_o     (period),
    .no_reload_o  (no_reload),
    .inject_o     (tok_chain[0]),
    .tok_last_i   (tok_chain[TIMER_COUNT]),
    .hit_i        (|hits)
  );

  // Chain of slot cells, token enters at slot zero
  for (genvar g = 0; g < TIMER_COUNT; g++) begin : g_cell
    mstt_cell #(
      .COUNT_WIDTH(COUNT_WIDTH),
      .INDEX      (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .cmd_i       (cmd),
      .period_i    (period),
      .no_reload_i (no_reload),
      .tok_i       (tok_chain[g]),
      .tok_o       (tok_chain[g+1]),
      .hit_o       (hits[g])
    );
  end

  `MSTT_ASSERT(a_one_token, $onehot0(tok_chain[TIMER_COUNT:1]), "more than one token in chain")
  `MSTT_NEVER(a_hit_no_token, (hits != '0) && (tok_chain[TIMER_COUNT:1] == '0), "hit without token")

endmodule

### sim/tb_multi_slot_timer_table.sv
// Self-checking testbench for the timer slot table: directed table, random commands, scoreboard.
module tb_multi_slot_timer_table;
  timeunit 1ns;
  timeprecision 1ps;

  import mstt_pkg::*;

  localparam int SLOTS        = 8;
  localparam int RANDOM_CMDS  = 210;
  localparam int HOLD_AT      = 60;
  localparam int DRAIN_AT     = 140;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 24;
  localparam int MAX_REPORTS  = 20;

  typedef struct packed {
    reply_e     kind;
    status_e    status;
    logic [2:0] slot;
    logic       last;
  } result_t;

  // One row of the directed table; pinned rows carry their reply typed in
  typedef struct {
    kind_e       kind;
    logic [2:0]  slot;
    logic [15:0] period;
    logic        no_reload;
    bit          pinned;
    reply_e      reply;
    status_e     status;
    logic [2:0]  reply_slot;
  } cmd_row_t;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY
  } stall_mode_e;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  kind_e       kind       = KIND_START;
  logic [2:0]  timer_slot = '0;
  logic [15:0] period     = '0;
  logic        no_reload  = 1'b0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  logic [1:0]  reply_kind;
  logic        status;
  logic [2:0]  slot;
  logic        last;

  // Timer table mirror
  logic        armed     [SLOTS];
  logic [15:0] reload    [SLOTS];
  logic [15:0] countdown [SLOTS];
  logic        single    [SLOTS];
  int          first_free;

  result_t step_results    [$];
  result_t pending_results [$];

  int kind_seen [4];
  int error_count  = 0;
  int result_count = 0;
  int fire_count   = 0;
  int burst_left   = 0;
  int idle_cycles  = 0;
  bit hold_req     = 1'b0;

  cmd_row_t directed_rows [22] = '{
    '{KIND_START,    3'd5, 16'h0000, 1'b1, 1'b1, REPLY_START, STATUS_REJECT, 3'd0},
    '{KIND_DISPATCH, 3'd0, 16'h0000, 1'b0, 1'b1, REPLY_DONE,  STATUS_OK,     3'd0},
    '{KIND_STOP,     3'd7, 16'h0000, 1'b0, 1'b1, REPLY_STOP,  STATUS_OK,     3'd7},
    '{KIND_START,    3'd0, 16'hFFFF, 1'b0, 1'b1, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_STOP,     3'd0, 16'hFFFF, 1'b1, 1'b1, REPLY_STOP,  STATUS_OK,     3'd0},
    '{KIND_START,    3'd7, 16'h0001, 1'b1, 1'b1, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_START,    3'd0, 16'h0001, 1'b0, 1'b1, REPLY_START, STATUS_OK,     3'd1},
    '{KIND_START,    3'd0, 16'h0001, 1'b1, 1'b1, REPLY_START, STATUS_OK,     3'd2},
    '{KIND_START,    3'd0, 16'h0001, 1'b0, 1'b1, REPLY_START, STATUS_OK,     3'd3},
    '{KIND_START,    3'd0, 16'h0001, 1'b1, 1'b1, REPLY_START, STATUS_OK,     3'd4},
    '{KIND_START,    3'd0, 16'h0001, 1'b0, 1'b1, REPLY_START, STATUS_OK,     3'd5},
    '{KIND_START,    3'd0, 16'h0001, 1'b1, 1'b1, REPLY_START, STATUS_OK,     3'd6},
    '{KIND_START,    3'd0, 16'h0001, 1'b0, 1'b1, REPLY_START, STATUS_OK,     3'd7},
    '{KIND_START,    3'd3, 16'hFFFF, 1'b1, 1'b1, REPLY_START, STATUS_REJECT, 3'd0},
    '{KIND_TICK,     3'd2, 16'hAAAA, 1'b0, 1'b0, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_TICK,     3'd5, 16'h5555, 1'b1, 1'b0, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_DISPATCH, 3'd7, 16'hFFFF, 1'b1, 1'b0, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_DISPATCH, 3'd0, 16'h0000, 1'b0, 1'b0, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_TICK,     3'd0, 16'h0000, 1'b0, 1'b0, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_DISPATCH, 3'd0, 16'h0000, 1'b0, 1'b0, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_START,    3'd6, 16'h8000, 1'b1, 1'b0, REPLY_START, STATUS_OK,     3'd0},
    '{KIND_STOP,     3'd3, 16'h0000, 1'b0, 1'b1, REPLY_STOP,  STATUS_OK,     3'd3}
  };

  multi_slot_timer_table dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (kind),
    .timer_slot_i (timer_slot),
    .period_i     (period),
    .no_reload_i  (no_reload),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .reply_kind_o (reply_kind),
    .status_o     (status),
    .slot_o       (slot),
    .last_o       (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic result_t make_result(reply_e k, status_e st, logic [2:0] sl, logic lst);
    result_t r;
    r.kind   = k;
    r.status = st;
    r.slot   = sl;
    r.last   = lst;
    return r;
  endfunction

  // Point first_free at the lowest idle slot, or SLOTS when all are busy
  function automatic void find_first_free();
    first_free = SLOTS;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!armed[i]) first_free = i;
    end
  endfunction

  // Apply one command to the table mirror and collect the replies it causes
  function automatic void timer_table_predict(kind_e k, logic [2:0] ts, logic [15:0] per,
                                              logic os);
    int fires;
    fires = 0;
    step_results.delete();
    case (k)
      KIND_START: begin
        if (per == '0 || first_free >= SLOTS) begin
          step_results.push_back(make_result(REPLY_START, STATUS_REJECT, 3'd0, 1'b1));
        end else begin
          reload[first_free]    = per;
          countdown[first_free] = per;
          single[first_free]    = os;
          armed[first_free]     = 1'b1;
          step_results.push_back(make_result(REPLY_START, STATUS_OK, 3'(first_free), 1'b1));
          find_first_free();
        end
      end
      KIND_STOP: begin
        armed[ts] = 1'b0;
        find_first_free();
        step_results.push_back(make_result(REPLY_STOP, STATUS_OK, ts, 1'b1));
      end
      KIND_TICK: begin
        // Count down, saturating at zero
        for (int i = 0; i < SLOTS; i++) begin
          if (armed[i] && countdown[i] != '0) countdown[i] = countdown[i] - 16'd1;
        end
      end
      default: begin
        // Fire expired slots in ascending order: free one-shots, reload periodics
        for (int i = 0; i < SLOTS && fires < MaxFires; i++) begin
          if (armed[i] && countdown[i] == '0) begin
            if (single[i]) armed[i] = 1'b0;
            else countdown[i] = reload[i];
            step_results.push_back(make_result(REPLY_FIRE, STATUS_OK, 3'(i), 1'b0));
            fires++;
          end
        end
        find_first_free();
        step_results.push_back(make_result(REPLY_DONE, STATUS_OK, 3'd0, 1'b1));
      end
    endcase
  endfunction

  task automatic report_mismatch(string what);
    if (error_count < MAX_REPORTS) $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Offer one command beat, hold it until taken, then queue its replies
  task automatic send_cmd(kind_e k, logic [2:0] ts, logic [15:0] per, logic os,
                          bit pinned = 1'b0, result_t pin = '0);
    in_valid   <= 1'b1;
    kind       <= k;
    timer_slot <= ts;
    period     <= per;
    no_reload  <= os;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    timer_table_predict(k, ts, per, os);
    if (pinned) begin
      pending_results.push_back(pin);
    end else begin
      foreach (step_results[i]) pending_results.push_back(step_results[i]);
    end
    kind_seen[k]++;
    // End the burst with a random gap
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = $urandom_range(0, 12);
    end
  endtask

  task automatic run_random();
    int          pick;
    kind_e       k;
    logic [15:0] per;
    for (int n = 0; n < RANDOM_CMDS; n++) begin
      // Let the receiver back up while commands keep coming
      if (n == HOLD_AT) hold_req = 1'b1;
      // Pause until every reply is home
      if (n == DRAIN_AT) begin
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        @(posedge clk);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) k = KIND_START;
      else if (pick < 50) k = KIND_STOP;
      else if (pick < 78) k = KIND_TICK;
      else k = KIND_DISPATCH;
      // Mostly short periods so slots expire; some zero, some full width
      pick = $urandom_range(0, 9);
      if (k != KIND_START || pick == 9) per = 16'($urandom);
      else if (pick == 0) per = '0;
      else if (pick <= 6) per = 16'($urandom_range(1, 4));
      else per = 16'($urandom_range(5, 40));
      send_cmd(k, 3'($urandom_range(0, 7)), per, 1'($urandom_range(0, 1)));
    end
  endtask

  // Check each reply beat against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected beat kind %0d status %0d slot %0d last %0d",
                                  reply_kind, status, slot, last));
      end else begin
        want = pending_results.pop_front();
        if (reply_kind != want.kind)
          report_mismatch($sformatf("reply_kind %0d, wanted %0d", reply_kind, want.kind));
        if (status != want.status)
          report_mismatch($sformatf("status %0d, wanted %0d", status, want.status));
        if (slot != want.slot)
          report_mismatch($sformatf("slot %0d, wanted %0d", slot, want.slot));
        if (last != want.last)
          report_mismatch($sformatf("last %0d, wanted %0d", last, want.last));
        if (want.kind == REPLY_FIRE) fire_count++;
        result_count++;
      end
    end
  end

  // Stall the reply channel in phases of its own, plus one long hold-off
  initial begin
    stall_mode_e mode;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end
      mode = stall_mode_e'($urandom_range(0, 2));
      repeat ($urandom_range(4, 40)) begin
        case (mode)
          STALL_NONE:  out_stall <= 1'b0;
          STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
          default:     out_stall <= ($urandom_range(0, 3) != 0);
        endcase
        @(posedge clk);
      end
    end
  end

  // Abort when no beat moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no beat for %0d cycles, %0d replies outstanding",
                 IDLE_LIMIT, pending_results.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    foreach (armed[i]) armed[i] = 1'b0;
    foreach (kind_seen[i]) kind_seen[i] = 0;
    first_free = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (directed_rows[i]) begin
      send_cmd(directed_rows[i].kind, directed_rows[i].slot, directed_rows[i].period,
               directed_rows[i].no_reload, directed_rows[i].pinned,
               make_result(directed_rows[i].reply, directed_rows[i].status,
                           directed_rows[i].reply_slot, 1'b1));
    end
    run_random();

    // Drain and settle
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d starts, %0d stops, %0d ticks and %0d dispatches in bursts with gaps",
             kind_seen[KIND_START], kind_seen[KIND_STOP], kind_seen[KIND_TICK],
             kind_seen[KIND_DISPATCH]);
    $display("checked %0d reply beats (%0d fires) through a %0d-cycle hold-off and a drain",
             result_count, fire_count, HOLD_CYCLES);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### multi_slot_timer_table.f
+incdir+sv
sv/mstt_pkg.sv
sv/mstt_cell.sv
sv/mstt_ctrl.sv
sv/multi_slot_timer_table.sv
sim/tb_multi_slot_timer_table.sv
